FILE: rtl/core/bclb_pkg.sv
// Shared types and constants for the button controlled LED blinker.
package bclb_pkg;

  localparam int unsigned HpW  = 30;
  localparam int unsigned ElW  = 31;
  localparam int unsigned DurW = 32;
  localparam int unsigned AddrW = 4;

  localparam logic [HpW-1:0]  DefaultHpReset = 30'd500000000;
  localparam logic [HpW-1:0]  TickStepReset  = 30'd10000000;
  localparam logic [DurW-1:0] ThresholdReset = 32'd1000000000;

  localparam logic [1:0] RegDefaultHp = 2'd0;
  localparam logic [1:0] RegTickStep  = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef struct packed {
    logic [HpW-1:0]  default_half_period;
    logic [HpW-1:0]  tick_step;
    logic [DurW-1:0] long_press_threshold;
  } cfg_t;

  typedef struct packed {
    logic [HpW-1:0]  half_period;
    logic [ElW-1:0]  elapsed_time;
    logic            led_phase_off;
    logic            previous_button;
    logic            pressing;
    logic [DurW-1:0] press_duration;
  } state_t;

endpackage

FILE: rtl/core/bclb_if.sv
// Valid/ready channel interfaces for tick input and blinker result.
interface bclb_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface bclb_out_if;
  logic        valid;
  logic        ready;
  logic        led_level;
  logic [1:0]  press_event;
  logic [29:0] current_half_period;

  modport source (output valid, output led_level, output press_event,
                  output current_half_period, input ready);
  modport sink (input valid, input led_level, input press_event,
                input current_half_period, output ready);
endinterface

FILE: rtl/core/bclb_next.sv
// Next-state and result logic for one tick of the blinker.
module bclb_next (
  input  bclb_pkg::state_t state_i,
  input  bclb_pkg::cfg_t   cfg_i,
  input  logic             button_level_i,
  output bclb_pkg::state_t state_o,
  output logic             led_level_o,
  output bclb_pkg::event_e press_event_o
);
  import bclb_pkg::*;

  always_comb begin
    logic [DurW:0]  dur_sum;
    logic [ElW-1:0] el_base;
    logic [ElW-1:0] el_sum;
    logic           phase_base;
    logic           blink;

    state_o       = state_i;
    led_level_o   = 1'b1;
    press_event_o = EV_NONE;
    blink         = 1'b0;
    el_base       = state_i.elapsed_time;
    phase_base    = state_i.led_phase_off;
    dur_sum       = {1'b0, state_i.press_duration} + {3'b000, cfg_i.tick_step};

    if (state_i.pressing) begin
      if (!button_level_i) begin
        state_o.press_duration = dur_sum[DurW] ? '1 : dur_sum[DurW-1:0];
      end else begin
        if (state_i.press_duration < cfg_i.long_press_threshold) begin
          press_event_o       = EV_SHORT;
          state_o.half_period = state_i.half_period >> 1;
        end else begin
          press_event_o       = EV_LONG;
          state_o.half_period = cfg_i.default_half_period;
        end
        state_o.pressing       = 1'b0;
        state_o.press_duration = '0;
        el_base                = '0;
        phase_base             = 1'b0;
        blink                  = 1'b1;
      end
    end else if (state_i.previous_button && !button_level_i) begin
      state_o.pressing       = 1'b1;
      state_o.press_duration = {2'b00, cfg_i.tick_step};
    end else begin
      blink = 1'b1;
    end

    el_sum = el_base + {1'b0, cfg_i.tick_step};

    if (blink) begin
      led_level_o = phase_base;
      if (el_sum >= {1'b0, state_o.half_period}) begin
        state_o.led_phase_off = !phase_base;
        state_o.elapsed_time  = '0;
      end else begin
        state_o.led_phase_off = phase_base;
        state_o.elapsed_time  = el_sum;
      end
    end

    state_o.previous_button = button_level_i;
  end

endmodule

FILE: rtl/core/button_controlled_led_blinker_unit.sv
// Top level of the button controlled LED blinker with APB register port.
//
// One tick transaction is taken every clock cycle unless input ready is low:
// the tick is captured in an input register, and once the result register is
// free or being taken, the next-state logic (one 33-bit add with saturation,
// one 31-bit add and two compares) updates the blink and press state, and the
// LED level, press event and period land in a result register. While a result
// waits downstream the input register takes at most one more tick; once both
// registers are full, input ready stays low for every cycle that the result
// is not taken. Registers: 0x0 default half period, 0x4 tick step, 0x8 long
// press threshold, all in nanoseconds; a new default takes effect at the next
// long press.
module button_controlled_led_blinker_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bclb_in_if.sink                    in_i,
  bclb_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bclb_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bclb_pkg::*;

  cfg_t   cfg_q;
  state_t st_q;
  state_t st_d;

  logic   in_valid_q;
  logic   in_level_q;
  logic   out_valid_q;
  logic   out_led_q;
  event_e out_event_q;
  logic [HpW-1:0] out_hp_q;

  logic   led_d;
  event_e event_d;
  logic   advance;
  logic   cfg_write;
  logic [1:0] reg_idx;

  assign reg_idx   = paddr[3:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      RegDefaultHp: prdata = {2'b00, cfg_q.default_half_period};
      RegTickStep:  prdata = {2'b00, cfg_q.tick_step};
      RegThreshold: prdata = cfg_q.long_press_threshold;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_half_period  <= DefaultHpReset;
      cfg_q.tick_step            <= TickStepReset;
      cfg_q.long_press_threshold <= ThresholdReset;
    end else if (cfg_write) begin
      case (reg_idx)
        RegDefaultHp: cfg_q.default_half_period  <= pwdata[HpW-1:0];
        RegTickStep:  cfg_q.tick_step            <= pwdata[HpW-1:0];
        RegThreshold: cfg_q.long_press_threshold <= pwdata;
        default: ;
      endcase
    end
  end

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;

  bclb_next u_next (
    .state_i        (st_q),
    .cfg_i          (cfg_q),
    .button_level_i (in_level_q),
    .state_o        (st_d),
    .led_level_o    (led_d),
    .press_event_o  (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_level_q <= in_i.button_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.half_period     <= DefaultHpReset;
      st_q.elapsed_time    <= '0;
      st_q.led_phase_off   <= 1'b0;
      st_q.previous_button <= 1'b1;
      st_q.pressing        <= 1'b0;
      st_q.press_duration  <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_led_q   <= led_d;
      out_event_q <= event_d;
      out_hp_q    <= st_d.half_period;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.led_level           = out_led_q;
  assign out_o.press_event         = out_event_q;
  assign out_o.current_half_period = out_hp_q;

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_idle_no_duration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pressing |-> (st_q.press_duration == '0))
    else $error("press duration held outside a press");

  a_event_led_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_event_q != EV_NONE) |-> !out_led_q)
    else $error("press event reported with LED off");

  a_held_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && st_q.pressing && !in_level_q) |=> (out_valid_q && out_led_q))
    else $error("LED not held off during press");

  a_elapsed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pressing |-> (st_q.elapsed_time < {1'b0, st_q.half_period}
                        || st_q.elapsed_time == '0))
    else $error("elapsed time ran past the half period");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the button controlled LED blinker unit.
module tb_top;
  import bclb_pkg::*;

  typedef struct packed {
    logic           led;
    event_e         ev;
    logic [HpW-1:0] hp;
  } blink_result_t;

  class blink_scoreboard;
    logic [HpW-1:0]  dflt_hp;
    logic [HpW-1:0]  tick_ns;
    logic [DurW-1:0] long_thr;
    logic [HpW-1:0]  half_period;
    logic [ElW-1:0]  elapsed;
    bit              phase_off;
    bit              prev_level;
    bit              pressing;
    logic [DurW-1:0] press_ns;
    blink_result_t   results_due[$];
    int              errors;

    function new();
      dflt_hp     = DefaultHpReset;
      tick_ns     = TickStepReset;
      long_thr    = ThresholdReset;
      half_period = DefaultHpReset;
      elapsed     = '0;
      phase_off   = 1'b0;
      prev_level  = 1'b1;
      pressing    = 1'b0;
      press_ns    = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegDefaultHp: dflt_hp = value[HpW-1:0];
        RegTickStep:  tick_ns = value[HpW-1:0];
        RegThreshold: long_thr = value;
        default: ;
      endcase
    endfunction

    function void predict_tick(logic level);
      blink_result_t r;
      logic [DurW:0] sum;
      bit            blink;
      r.led = 1'b1;
      r.ev  = EV_NONE;
      blink = 1'b0;
      if (pressing) begin
        if (!level) begin
          sum      = {1'b0, press_ns} + {3'b000, tick_ns};
          press_ns = sum[DurW] ? '1 : sum[DurW-1:0];
        end else begin
          if (press_ns < long_thr) begin
            r.ev        = EV_SHORT;
            half_period = half_period >> 1;
          end else begin
            r.ev        = EV_LONG;
            half_period = dflt_hp;
          end
          pressing  = 1'b0;
          press_ns  = '0;
          phase_off = 1'b0;
          elapsed   = '0;
          blink     = 1'b1;
        end
      end else if (prev_level && !level) begin
        pressing = 1'b1;
        press_ns = {2'b00, tick_ns};
      end else begin
        blink = 1'b1;
      end
      if (blink) begin
        r.led   = phase_off;
        elapsed = elapsed + tick_ns;
        if (elapsed >= half_period) begin
          phase_off = !phase_off;
          elapsed   = '0;
        end
      end
      prev_level = level;
      r.hp       = half_period;
      results_due.push_back(r);
    endfunction

    function void check_result(logic led, logic [1:0] ev, logic [HpW-1:0] hp);
      blink_result_t exp_r;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result led=%0b event=%0d period=%0d", $time, led, ev, hp);
        errors++;
        return;
      end
      exp_r = results_due.pop_front();
      if (led !== exp_r.led) begin
        $display("%0t: led_level expected %0b actual %0b", $time, exp_r.led, led);
        errors++;
      end
      if (ev !== exp_r.ev) begin
        $display("%0t: press_event expected %0d actual %0d", $time, exp_r.ev, ev);
        errors++;
      end
      if (hp !== exp_r.hp) begin
        $display("%0t: current_half_period expected %0d actual %0d", $time, exp_r.hp, hp);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                snd_pct = 0;
  int                rcv_pct = 0;
  logic              hold_req = 1'b0;
  blink_scoreboard   sb;

  bclb_in_if  tick_if ();
  bclb_out_if res_if ();

  button_controlled_led_blinker_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #2400000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.led_level, res_if.press_event, res_if.current_half_period);
    end
  end

  task automatic send_tick(logic level);
    tick_if.valid        <= 1'b1;
    tick_if.button_level <= level;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    sb.predict_tick(level);
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
  endtask

  task automatic configure(logic [29:0] dflt, logic [29:0] tick, logic [31:0] thr);
    tick_if.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_write(RegDefaultHp, {2'b00, dflt});
    apb_write(RegTickStep, {2'b00, tick});
    apb_write(RegThreshold, thr);
  endtask

  task automatic press_cycles(int count, int max_rel, int max_press);
    int sent;
    int rel;
    int held;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        rel  = $urandom_range(max_rel, 1);
        held = $urandom_range(max_press, 1);
        repeat (rel) send_tick(1'b1);
        repeat (held) send_tick(1'b0);
        sent += rel + held;
      end else begin
        send_tick(1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic run_phase(int idx, logic [29:0] dflt, logic [29:0] tick, logic [31:0] thr,
                           int max_rel, int max_press, int count);
    configure(dflt, tick, thr);
    case (idx % 4)
      0: begin snd_pct = 0;  rcv_pct <= 0;  end
      1: begin snd_pct = 52; rcv_pct <= 0;  end
      2: begin snd_pct = 0;  rcv_pct <= 52; end
      default: begin snd_pct = 14; rcv_pct <= 14; end
    endcase
    if (idx == 0) hold_req <= ~hold_req;
    press_cycles(count, max_rel, max_press);
  endtask

  initial begin
    sb = new();
    tick_if.valid        <= 1'b0;
    tick_if.button_level <= 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    configure(30'h3FFFFFFF, 30'h3FFFFFFF, 32'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    configure(30'd1, 30'd0, 32'd0);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    configure(30'd1, 30'd0, 32'hFFFFFFFF);
    send_tick(1'b0);
    repeat (4) send_tick(1'b1);

    run_phase(0, DefaultHpReset, TickStepReset, ThresholdReset, 120, 150, 300);
    run_phase(1, 30'd6, 30'd1, 32'd5, 15, 9, 200);
    run_phase(2, 30'd1000000000, 30'd1000000000, 32'd4000000000, 4, 6, 200);
    run_phase(3, 30'h3FFFFFFF, 30'h3FFFFFFF, 32'hFFFFFFFF, 4, 8, 200);
    run_phase(4, 30'd3, 30'd0, 32'd1, 5, 4, 150);
    run_phase(5, 30'd1, 30'd1, 32'd0, 4, 3, 150);
    run_phase(6, 30'($urandom_range(40)), 30'($urandom_range(8)),
              32'($urandom_range(60)), 30, 20, 350);

    tick_if.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bclb_pkg.sv
rtl/core/bclb_if.sv
rtl/core/bclb_next.sv
rtl/core/button_controlled_led_blinker_unit.sv
test/tb_top.sv
